// ----- sv/plla_pkg.sv -----
// Shared constants and types for the path line lookahead point block.
// No dependencies.
package plla_pkg;

    localparam int DIR_FRAC = 15;   // fraction bits of the direction registers
    localparam int SQ_ITERS = 32;   // square root stages, one result bit each
    localparam int SQ_W     = 64;   // width of the square root remainder/result

    typedef enum logic [2:0] {
        CFG_START_X  = 3'd0,
        CFG_START_Y  = 3'd1,
        CFG_END_X    = 3'd2,
        CFG_END_Y    = 3'd3,
        CFG_DIR_COS  = 3'd4,
        CFG_DIR_SIN  = 3'd5,
        CFG_SEG_LEN  = 3'd6,
        CFG_FINITE   = 3'd7
    } t_cfg_idx;

    // Per-word fields that ride along the square root stages.
    typedef struct packed {
        logic               action;
        logic               hit;
        logic signed [34:0] p;
        logic        [30:0] r;
    } t_carry;

endpackage

// ----- sv/path_line_lookahead_point.sv -----
// Throughput: one word per cycle unless the output stalls; the 32-stage square root sets the depth.
// Stall from the output freezes the whole pipe; the input stalls only then.
// Reset (i_rst_n low, synchronous) empties the pipe and loads the
// configuration defaults: cos = 32767, finite mode on, all else zero.
// Depends on plla_pkg.
module path_line_lookahead_point import plla_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    // query words
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic [30:0]        i_radius,
    // result words
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y
);

    // ---------------- configuration registers ----------------
    logic signed [31:0] r_start_x, r_start_y, r_end_x, r_end_y;
    logic signed [15:0] r_dir_cos, r_dir_sin;
    logic [30:0]        r_seg_len;
    logic               r_finite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
            r_dir_cos <= 16'sd32767;
            r_dir_sin <= '0;
            r_seg_len <= '0;
            r_finite  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_X: r_start_x <= i_cfg_data;
                CFG_START_Y: r_start_y <= i_cfg_data;
                CFG_END_X:   r_end_x   <= i_cfg_data;
                CFG_END_Y:   r_end_y   <= i_cfg_data;
                CFG_DIR_COS: r_dir_cos <= i_cfg_data[15:0];
                CFG_DIR_SIN: r_dir_sin <= i_cfg_data[15:0];
                CFG_SEG_LEN: r_seg_len <= i_cfg_data[30:0];
                CFG_FINITE:  r_finite  <= i_cfg_data[0];
                default:     r_finite  <= r_finite;
            endcase
        end
    end

    // Whole pipe moves together; it holds only while a result waits.
    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // ---------------- stage 1: offset from line start ----------------
    logic               r_vld1, r1_action;
    logic signed [32:0] r1_rx, r1_ry;
    logic [30:0]        r1_r;

    // ---------------- stage 2: direction products ----------------
    logic               r_vld2, r2_action;
    logic signed [48:0] r2_xc, r2_ys, r2_xs, r2_yc;
    logic [30:0]        r2_r;
    logic signed [48:0] n2_xc, n2_ys, n2_xs, n2_yc;

    assign n2_xc = r1_rx * r_dir_cos;
    assign n2_ys = r1_ry * r_dir_sin;
    assign n2_xs = r1_rx * r_dir_sin;
    assign n2_yc = r1_ry * r_dir_cos;

    // ---------------- stage 3: projection p and cross term d ----------------
    logic               r_vld3, r3_action;
    logic signed [34:0] r3_p, r3_d;
    logic [30:0]        r3_r;
    logic signed [49:0] n3_psum, n3_dsum;

    assign n3_psum = {r2_xc[48], r2_xc} + {r2_ys[48], r2_ys};
    assign n3_dsum = {r2_xs[48], r2_xs} - {r2_yc[48], r2_yc};

    // ---------------- stage 4: |d| and circle hit test ----------------
    logic               r_vld4, r4_action, r4_hit;
    logic signed [34:0] r4_p;
    logic [30:0]        r4_r;
    logic [30:0]        r4_ad;
    logic [34:0]        n4_ad;

    assign n4_ad = r3_d[34] ? 35'(-r3_d) : 35'(r3_d);

    // ---------------- stage 5: squares ----------------
    logic               r_vld5;
    t_carry             r5_cy;
    logic [61:0]        r5_rr, r5_aa;

    // ---------------- stage 6 + square root pipe ----------------
    // Index 0 holds the discriminant, index k+1 the state after bit k.
    logic               r_sq_vld [0:SQ_ITERS];
    t_carry             r_sq_cy  [0:SQ_ITERS];
    logic [SQ_W-1:0]    r_sq_v   [0:SQ_ITERS];
    logic [SQ_W-1:0]    r_sq_res [0:SQ_ITERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_sq_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_sq_vld[0] <= r_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_action <= i_action;
            r1_r      <= i_radius;
            r1_rx     <= {i_pose_x[31], i_pose_x} - {r_start_x[31], r_start_x};
            r1_ry     <= {i_pose_y[31], i_pose_y} - {r_start_y[31], r_start_y};

            r2_action <= r1_action;
            r2_r      <= r1_r;
            r2_xc     <= n2_xc;
            r2_ys     <= n2_ys;
            r2_xs     <= n2_xs;
            r2_yc     <= n2_yc;

            // arithmetic shift right is the floor shift
            r3_action <= r2_action;
            r3_r      <= r2_r;
            r3_p      <= 35'(n3_psum >>> DIR_FRAC);
            r3_d      <= 35'(n3_dsum >>> DIR_FRAC);

            r4_action <= r3_action;
            r4_r      <= r3_r;
            r4_p      <= r3_p;
            r4_hit    <= (n4_ad <= {4'd0, r3_r});
            r4_ad     <= n4_ad[30:0];

            r5_cy.action <= r4_action;
            r5_cy.hit    <= r4_hit;
            r5_cy.p      <= r4_p;
            r5_cy.r      <= r4_r;
            r5_rr        <= r4_r * r4_r;
            r5_aa        <= r4_ad * r4_ad;

            r_sq_cy[0]  <= r5_cy;
            r_sq_v[0]   <= r5_cy.hit ? {2'b00, r5_rr - r5_aa} : '0;
            r_sq_res[0] <= '0;
        end
    end

    // One result bit per stage, restoring integer square root.
    for (genvar k = 0; k < SQ_ITERS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] w_trial;
        logic            w_ge;

        assign w_trial = r_sq_res[k] + BIT;
        assign w_ge    = (r_sq_v[k] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq_cy[k+1]  <= r_sq_cy[k];
                r_sq_v[k+1]   <= w_ge ? r_sq_v[k] - w_trial : r_sq_v[k];
                r_sq_res[k+1] <= w_ge ? (r_sq_res[k] >> 1) + BIT : r_sq_res[k] >> 1;
            end
        end
    end

    // ---------------- stage T: roots and projection, clamped when finite ----------------
    t_carry             w_sqo;
    logic signed [35:0] w_p36, w_s36, w_seg36;
    logic signed [35:0] n_c;

    assign w_sqo   = r_sq_cy[SQ_ITERS];
    assign w_p36   = {w_sqo.p[34], w_sqo.p};
    assign w_s36   = {4'd0, r_sq_res[SQ_ITERS][31:0]};
    assign w_seg36 = {5'd0, r_seg_len};

    always_comb begin
        n_c = w_p36;
        if (r_finite) begin
            if (w_p36 < 0) begin
                n_c = '0;
            end else if (w_p36 > w_seg36) begin
                n_c = w_seg36;
            end
        end
    end

    logic               r_vldt;
    logic               rt_action, rt_hit;
    logic [30:0]        rt_r;
    logic signed [35:0] rt_t1, rt_t2, rt_c;

    // ---------------- stage D: choose line parameter or end point ----------------
    logic signed [35:0] n_a, n_t;
    logic               n_end;
    logic               w_in1, w_in2;

    assign n_a   = rt_c + {5'd0, rt_r};
    assign w_in1 = (rt_t1 >= 0) && (rt_t1 <= w_seg36);
    assign w_in2 = (rt_t2 >= 0) && (rt_t2 <= w_seg36);

    always_comb begin
        n_t   = n_a;
        n_end = 1'b0;
        if (!rt_action) begin
            n_t = rt_c;                      // closest point
        end else if (rt_hit && (!r_finite || w_in1)) begin
            n_t = rt_t1;                     // far intersection
        end else if (rt_hit && w_in2) begin
            n_end = 1'b1;                    // far root past the end
        end else if (r_finite && (n_a >= w_seg36)) begin
            n_end = 1'b1;                    // no root on the segment, advanced past the end
        end
    end

    logic               r_vldd, rd_end;
    logic signed [35:0] rd_t;

    // ---------------- stage M: t times direction ----------------
    logic               r_vldm, rm_end;
    logic signed [51:0] rm_mx, rm_my;
    logic signed [51:0] n_mx, n_my;

    assign n_mx = rd_t * r_dir_cos;
    assign n_my = rd_t * r_dir_sin;

    // ---------------- stage O: add start and saturate, or take end point ----------------
    logic signed [37:0] n_x, n_y;
    logic signed [31:0] n_sx, n_sy;

    assign n_x = {{6{r_start_x[31]}}, r_start_x} + 38'(rm_mx >>> DIR_FRAC);
    assign n_y = {{6{r_start_y[31]}}, r_start_y} + 38'(rm_my >>> DIR_FRAC);

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] res;
        if (v > 38'sh0007FFFFFFF) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -38'sh0080000000) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    assign n_sx = rm_end ? r_end_x : sat32(n_x);
    assign n_sy = rm_end ? r_end_y : sat32(n_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldt  <= 1'b0;
            r_vldd  <= 1'b0;
            r_vldm  <= 1'b0;
            o_valid <= 1'b0;
        end else if (w_adv) begin
            r_vldt  <= r_sq_vld[SQ_ITERS];
            r_vldd  <= r_vldt;
            r_vldm  <= r_vldd;
            o_valid <= r_vldm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rt_action <= w_sqo.action;
            rt_hit    <= w_sqo.hit;
            rt_r      <= w_sqo.r;
            rt_t1     <= w_p36 + w_s36;
            rt_t2     <= w_p36 - w_s36;
            rt_c      <= n_c;

            rd_t      <= n_t;
            rd_end    <= n_end;

            rm_mx     <= n_mx;
            rm_my     <= n_my;
            rm_end    <= rd_end;

            o_point_x <= n_sx;
            o_point_y <= n_sy;
        end
    end

endmodule

// ----- sv/plla_checker.sv -----
// Port-level checks for path_line_lookahead_point, bound to the top level.
// Depends on plla_pkg only through the bound module.
module plla_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_point_x,
    input logic signed [31:0] o_point_y
);

    // input side stalls only while a result word waits
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stall without a waiting result");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_point_x) && $stable(o_point_y)))
        else $error("result changed while stalled");

endmodule

bind path_line_lookahead_point plla_checker u_plla_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_point_x (o_point_x),
    .o_point_y (o_point_y)
);
